>>> rtl/box_blur_3x3_rgb_gray_top_assert.svh
// Assertion macros shared by the box blur RTL modules.
`ifndef BOX_BLUR_3X3_RGB_GRAY_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_GRAY_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and held off during reset.
`define BB3_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and held off during reset.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bb3_pkg.sv
// Types, register codes and divide-by-constant helpers for the box blur.
package bb3_pkg;

    // One RGB pixel, red in the low byte, blue in the high byte.
    typedef logic [23:0] t_pix;

    // Per-channel nine-pixel sums (max 9 * 255 = 2295).
    typedef logic [2:0][11:0] t_sums;

    // Position and flags that travel with each request through the pipeline.
    typedef struct packed {
        logic        emit;
        logic        last;
        logic [11:0] row;
        logic [9:0]  col;
    } t_tag;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GRAY_ENABLE  = 2'd2;

    // Reciprocals scaled by 2^16, rounded up; exact for the input ranges used.
    localparam logic [12:0] DIV9_MUL = 13'd7282;
    localparam logic [14:0] DIV3_MUL = 15'd21846;

    // Floor of x / 9 for x up to 2295.
    function automatic logic [7:0] div9(input logic [11:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'(DIV9_MUL);
        return p[23:16];
    endfunction

    // Floor of x / 3 for x up to 765.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'(DIV3_MUL);
        return p[23:16];
    endfunction

endpackage

>>> rtl/bb3_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds while read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bb3_window.sv
// Line store, 3x3 window registers and the per-channel nine-pixel sums.
`include "box_blur_3x3_rgb_gray_top_assert.svh"

module bb3_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_s1_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  bb3_pkg::t_pix                i_pix,
    output bb3_pkg::t_sums               o_sum
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic [AW-1:0]   r_wr_addr;
    bb3_pkg::t_pix   r_pix;
    bb3_pkg::t_pix   r_win [6];
    bb3_pkg::t_sums  r_sum;
    bb3_pkg::t_sums  n_sum;
    logic [47:0]     ram_rdata;
    bb3_pkg::t_pix   top_px;
    bb3_pkg::t_pix   mid_px;
    logic            ram_we;

    // Each entry holds the two previous rows at one column: top in the high half.
    assign top_px = ram_rdata[47:24];
    assign mid_px = ram_rdata[23:0];
    assign ram_we = i_adv && i_s1_valid;

    bb3_ram #(
        .WIDTH (48),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_addr),
        .i_wdata ({mid_px, r_pix}),
        .i_re    (i_adv),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_rdata)
    );

    // Capture the new pixel and its column alongside the line store read.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pix     <= i_pix;
            r_wr_addr <= i_rd_addr;
        end
    end

    // Shift the window by one column as the request leaves this stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (ram_we) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top_px;
            r_win[4] <= mid_px;
            r_win[5] <= r_pix;
        end
    end

    // Sum the nine window pixels per channel as an adder tree.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = ((12'(r_win[0][8*c +: 8]) + 12'(r_win[1][8*c +: 8]))
                      + (12'(r_win[2][8*c +: 8]) + 12'(r_win[3][8*c +: 8])))
                     + ((12'(r_win[4][8*c +: 8]) + 12'(r_win[5][8*c +: 8]))
                      + (12'(top_px[8*c +: 8]) + 12'(mid_px[8*c +: 8])))
                     + 12'(r_pix[8*c +: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

    // A write-back never targets the column being read in the same cycle.
    `BB3_ASSERT_IMPL(a_no_addr_clash, ram_we, r_wr_addr != i_rd_addr, "line store clash")

endmodule

>>> rtl/bb3_scale.sv
// Divide-by-nine and optional gray conversion of the window sums.
module bb3_scale (
    input  logic           i_clk,
    input  logic           i_adv,
    input  logic           i_gray,
    input  bb3_pkg::t_sums i_sum,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue
);

    logic [2:0][7:0] r_avg;
    logic [9:0]      r_gsum;
    logic [2:0][7:0] n_avg;
    logic [2:0][7:0] r_res;
    logic [7:0]      gray;

    // Channel averages and their total for the gray mean.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_avg[c] = bb3_pkg::div9(i_sum[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_avg  <= n_avg;
            r_gsum <= 10'(n_avg[0]) + 10'(n_avg[1]) + 10'(n_avg[2]);
        end
    end

    // Final pixel into the output register.
    assign gray = bb3_pkg::div3(r_gsum);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_gray) begin
                r_res <= {gray, gray, gray};
            end else begin
                r_res <= r_avg;
            end
        end
    end

    assign o_red   = r_res[0];
    assign o_green = r_res[1];
    assign o_blue  = r_res[2];

endmodule

>>> rtl/box_blur_3x3_rgb_gray_top.sv
// Top level of the 3x3 box blur with optional gray output.
//
// Pixels enter in raster order on the input channel (i_valid / o_ready) and
// blurred pixels leave on the output channel (o_valid / i_ready). Each
// request is one pixel; a result appears only once the 3x3 window is full,
// so a frame of W x H pixels gives (W-2) x (H-2) results, tagged with their
// row, column and a frame-last flag on the final one.
// Throughput is one pixel per cycle while the receiver takes results: the
// line store is one RAM read and one write-back per pixel at different
// columns, and every later stage is a plain register stage.
// A pixel passes the line store read, sum, average and output registers in turn.
// The pipeline moves as a whole whenever the output register is empty or
// being taken; while the receiver stalls with a result waiting, o_ready is
// low and every stage holds.
// Configuration writes (width, height, gray mode) take effect at once and
// are meant to happen only while the block is empty.
// Synchronous active-low reset clears the raster counters, the window and
// the pipeline, and restores width 1024, height 4095 and gray mode on. The
// line store needs no clearing: a full window only reads columns already
// written in the current frame.
`include "box_blur_3x3_rgb_gray_top_assert.svh"

module box_blur_3x3_rgb_gray_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata,
    // Input pixel channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    // Output pixel channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [11:0] o_out_row,
    output logic [9:0]  o_out_col,
    output logic        o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [10:0]   r_image_width;
    logic [11:0]   r_image_height;
    logic          r_gray_enable;
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;
    logic [CW-1:0] n_col;
    logic [11:0]   n_row;
    logic          r_s1_valid;
    logic          r_s2_valid;
    logic          r_s3_valid;
    logic          r_out_valid;
    bb3_pkg::t_tag r_s1_tag;
    bb3_pkg::t_tag r_s2_tag;
    bb3_pkg::t_tag r_s3_tag;
    bb3_pkg::t_tag r_out_tag;
    bb3_pkg::t_tag n_tag;
    bb3_pkg::t_sums win_sum;
    logic [31:0]   w_eff;
    logic [31:0]   h_eff;
    logic [31:0]   col_p1;
    logic [31:0]   col_m2;
    logic [12:0]   row_p1;
    logic          adv;
    logic          accept;

    // Whole-pipeline advance: output register empty or being taken.
    assign adv     = !r_out_valid || i_ready;
    assign accept  = i_valid && adv;
    assign o_ready = adv;

    // Clamp the configured frame size to the supported range.
    always_comb begin
        if (32'(r_image_width) < 32'd3) begin
            w_eff = 32'd3;
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = 32'(r_image_width);
        end
        if (r_image_height < 12'd3) begin
            h_eff = 32'd3;
        end else begin
            h_eff = 32'(r_image_height);
        end
    end

    // Raster counters and the tag of the pixel being accepted.
    assign col_p1 = 32'(r_col) + 32'd1;
    assign col_m2 = 32'(r_col) - 32'd2;
    assign row_p1 = 13'(r_row) + 13'd1;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_p1 >= w_eff) begin
            n_col = '0;
            if (32'(row_p1) >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = row_p1[11:0];
            end
        end else begin
            n_col = col_p1[CW-1:0];
        end
    end

    always_comb begin
        n_tag.emit = (r_row >= 12'd2) && (32'(r_col) >= 32'd2);
        n_tag.last = (32'(r_row) == h_eff - 32'd1) && (32'(r_col) == w_eff - 32'd1);
        n_tag.row  = r_row - 12'd2;
        n_tag.col  = col_m2[9:0];
    end

    // Configuration registers, counters and pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 11'd1024;
            r_image_height <= 12'd4095;
            r_gray_enable  <= 1'b1;
            r_col          <= '0;
            r_row          <= '0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_s3_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bb3_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata[10:0];
                    bb3_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                    bb3_pkg::CFG_GRAY_ENABLE:  r_gray_enable  <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (adv) begin
                r_s1_valid  <= accept;
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_out_valid <= r_s3_valid && r_s3_tag.emit;
            end
        end
    end

    // Tags follow their pixel through the stages.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_tag  <= n_tag;
            r_s2_tag  <= r_s1_tag;
            r_s3_tag  <= r_s2_tag;
            r_out_tag <= r_s3_tag;
        end
    end

    bb3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_s1_valid (r_s1_valid),
        .i_rd_addr  (r_col),
        .i_pix      ({i_blue_in, i_green_in, i_red_in}),
        .o_sum      (win_sum)
    );

    bb3_scale u_scale (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_gray  (r_gray_enable),
        .i_sum   (win_sum),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out)
    );

    assign o_valid      = r_out_valid;
    assign o_out_row    = r_out_tag.row;
    assign o_out_col    = r_out_tag.col;
    assign o_frame_last = r_out_tag.last;

    // An accepted request always enters the first stage.
    `BB3_ASSERT_NEXT(a_accept_enters, accept, r_s1_valid, "accepted request lost")
    // The frame-last pixel always lies inside the full-window region.
    `BB3_ASSERT_IMPL(a_last_emits, r_s1_valid && r_s1_tag.last, r_s1_tag.emit, "last without result")
    // A result leaving the last stage lands in the output register.
    `BB3_ASSERT_NEXT(a_result_out, adv && r_s3_valid && r_s3_tag.emit, o_valid, "result dropped")

endmodule
